@@ rtl/core/srpq_pkg.sv @@
// Package for the sorted ring priority queue.
// Holds the entry layout, operation codes and status codes; depends on nothing.
package srpq_pkg;

   localparam int DATA_W = 32;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // One stored entry: priority in the upper half, data in the lower half.
   typedef struct packed {
      logic signed [DATA_W-1:0] prio;
      logic signed [DATA_W-1:0] data;
   } entry_type;

endpackage

@@ rtl/core/srpq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; depends on no package.
module srpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sorted_ring_priority_queue.sv @@
// A full insert, a delete on an empty queue and an insert into an empty queue strobe their
// result in the cycle after start. Any other delete first reads the head slot, then ST_DEL;
// any other insert walks ST_CMP, then ST_LAST if it outranks all. Start is ignored while busy.
// A new transaction may start in the cycle its predecessor's result is strobed.
// Reset (synchronous, active high) empties the queue; slot contents are never cleared.
module sorted_ring_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic signed [srpq_pkg::DATA_W-1:0]   req_item_data,
   input  logic signed [srpq_pkg::DATA_W-1:0]   req_item_priority,
   output logic                                 rsp_valid,
   output srpq_pkg::status_type                 rsp_status,
   output logic signed [srpq_pkg::DATA_W-1:0]   rsp_removed_data,
   output logic signed [srpq_pkg::DATA_W-1:0]   rsp_removed_priority,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_occupancy
);

   import srpq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   // The queue is kept sorted from the head (highest priority) toward the tail.
   // An insert walks backward from the tail, one RAM read per cycle, moving each
   // strictly lower-priority entry one slot toward the tail until the new entry's
   // place is found. The new entry is held in registers during the walk.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEL,
      ST_CMP,
      ST_LAST
   } state_type;

   state_type             state_ff, state_in;
   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic [IW-1:0]         ahead_ff, ahead_in;
   entry_type             new_ff, new_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [DATA_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic [CW-1:0]         rsp_occ_ff, rsp_occ_in;

   // Slot RAM access.
   logic                  mem_we;
   logic [IW-1:0]         mem_waddr;
   entry_type             mem_wdata;
   logic                  mem_re;
   logic [IW-1:0]         mem_raddr;
   logic [$bits(entry_type)-1:0] mem_rdata;
   entry_type             rd_entry;

   logic [CW:0]           tail_sum;
   logic [IW-1:0]         tail_idx;

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
      if (idx == IW'(DEPTH-1)) begin
         return '0;
      end
      return idx + IW'(1);
   endfunction

   function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
      if (idx == '0) begin
         return IW'(DEPTH-1);
      end
      return idx - IW'(1);
   endfunction

   srpq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_entry = entry_type'(mem_rdata);

   // Slot just past the tail; head and count are both below DEPTH when this is
   // used, so one conditional subtract brings the sum back into the ring.
   always_comb begin
      tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      if (tail_sum >= (CW+1)'(DEPTH)) begin
         tail_sum = tail_sum - (CW+1)'(DEPTH);
      end
      tail_idx = tail_sum[IW-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      ahead_in      = ahead_ff;
      new_in        = new_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = new_ff;
      mem_re        = 1'b0;
      mem_raddr     = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               new_in.data = req_item_data;
               new_in.prio = req_item_priority;
               if (req_operation == OP_INSERT) begin
                  if (count_ff == CW'(DEPTH)) begin
                     // Full queue: report and leave everything as it is.
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_FULL;
                     rsp_data_in   = '0;
                     rsp_prio_in   = '0;
                     rsp_occ_in    = count_ff;
                  end else if (count_ff == '0) begin
                     // Nothing to pass: the entry lands directly in its slot.
                     mem_we           = 1'b1;
                     mem_waddr        = tail_idx;
                     mem_wdata.data   = req_item_data;
                     mem_wdata.prio   = req_item_priority;
                     count_in         = count_ff + CW'(1);
                     rsp_valid_in     = 1'b1;
                     rsp_status_in    = STATUS_OK;
                     rsp_data_in      = '0;
                     rsp_prio_in      = '0;
                     rsp_occ_in       = count_ff + CW'(1);
                  end else begin
                     pos_in    = tail_idx;
                     ahead_in  = count_ff[IW-1:0];
                     mem_re    = 1'b1;
                     mem_raddr = ring_prev(tail_idx);
                     state_in  = ST_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_data_in   = '0;
                     rsp_prio_in   = '0;
                     rsp_occ_in    = count_ff;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = head_ff;
                     state_in  = ST_DEL;
                  end
               end
            end
         end

         ST_DEL: begin
            // The head entry arrives from the RAM this cycle.
            head_in       = ring_next(head_ff);
            count_in      = count_ff - CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = rd_entry.data;
            rsp_prio_in   = rd_entry.prio;
            rsp_occ_in    = count_ff - CW'(1);
            state_in      = ST_IDLE;
         end

         ST_CMP: begin
            if (new_ff.prio > rd_entry.prio) begin
               // Move the lower-priority entry one slot toward the tail. The
               // next read never aims at the slot being written.
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = rd_entry;
               pos_in    = ring_prev(pos_ff);
               if (ahead_ff == IW'(1)) begin
                  state_in = ST_LAST;
               end else begin
                  ahead_in  = ahead_ff - IW'(1);
                  mem_re    = 1'b1;
                  mem_raddr = ring_prev(ring_prev(pos_ff));
               end
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = pos_ff;
               mem_wdata     = new_ff;
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = '0;
               rsp_prio_in   = '0;
               rsp_occ_in    = count_ff + CW'(1);
               state_in      = ST_IDLE;
            end
         end

         ST_LAST: begin
            // The new entry outranks everything and becomes the head.
            mem_we        = 1'b1;
            mem_waddr     = pos_ff;
            mem_wdata     = new_ff;
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = '0;
            rsp_prio_in   = '0;
            rsp_occ_in    = count_ff + CW'(1);
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      ahead_ff      <= ahead_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_data     = rsp_data_ff;
   assign rsp_removed_priority = rsp_prio_ff;
   assign rsp_occupancy        = rsp_occ_ff;

endmodule

@@ rtl/core/srpq_checker.sv @@
// Port-level assertions for the sorted ring priority queue, and the bind that attaches them.
// Depends on srpq_pkg and on the top level sorted_ring_priority_queue.
module srpq_checker #(
   parameter int DEPTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input srpq_pkg::status_type                rsp_status,
   input logic signed [srpq_pkg::DATA_W-1:0]  rsp_removed_data,
   input logic signed [srpq_pkg::DATA_W-1:0]  rsp_removed_priority,
   input logic [$clog2(DEPTH+1)-1:0]          rsp_occupancy
);

   import srpq_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   // An accepted transaction either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted transaction neither answered nor busy");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_occupancy == CW'(DEPTH)))
      else $error("full status without full occupancy");

   a_empty_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with nonzero occupancy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK)
         |-> (rsp_removed_data == '0 && rsp_removed_priority == '0))
      else $error("failed transaction returned a nonzero entry");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CW'(DEPTH)))
      else $error("occupancy beyond depth");

endmodule

bind sorted_ring_priority_queue srpq_checker #(.DEPTH(DEPTH)) u_srpq_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_status           (rsp_status),
   .rsp_removed_data     (rsp_removed_data),
   .rsp_removed_priority (rsp_removed_priority),
   .rsp_occupancy        (rsp_occupancy)
);

@@ bench/tb.sv @@
// Self-checking testbench for the sorted ring priority queue (sorted_ring_priority_queue).
// Depends on srpq_pkg for the entry layout, operation codes and status codes.
// A shadow queue predicts every result, which is checked field by field as it is strobed.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srpq_pkg::*;

   localparam int DEPTH = 16;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int RANDOM_OPS = 1500;

   // One queue operation as the driver presents it. The gap is the number of idle
   // cycles the driver inserts before it, and drain_first holds the operation back
   // until every outstanding result has been strobed.
   typedef struct {
      logic                     op;
      logic signed [DATA_W-1:0] data;
      logic signed [DATA_W-1:0] prio;
      int                       gap;
      bit                       drain_first;
   } queue_op_type;

   // The result that one operation must produce.
   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic signed [DATA_W-1:0] prio;
      logic [OCC_W-1:0]         occupancy;
   } queue_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_operation = OP_INSERT;
   logic signed [DATA_W-1:0] req_item_data = '0;
   logic signed [DATA_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   status_type               rsp_status;
   logic signed [DATA_W-1:0] rsp_removed_data;
   logic signed [DATA_W-1:0] rsp_removed_priority;
   logic [OCC_W-1:0]         rsp_occupancy;

   // Operations still to be driven, and results still to be strobed, oldest first.
   queue_op_type     op_backlog[$];
   queue_result_type awaited_results[$];

   // Shadow copy of the queue: ring storage, head pointer and entry count.
   entry_type   shadow_slots[DEPTH];
   int unsigned shadow_head = 0;
   int unsigned shadow_count = 0;

   int               mismatch_count = 0;
   int               gap_count = 0;
   logic             took = 1'b0;
   queue_op_type     next_op;
   queue_op_type     taken_op;
   queue_result_type want;

   always #6 clock = ~clock;

   sorted_ring_priority_queue #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_item_data        (req_item_data),
      .req_item_priority    (req_item_priority),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_removed_data     (rsp_removed_data),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_occupancy        (rsp_occupancy)
   );

   // Applies one operation to the shadow queue and returns the result it must give.
   // An insert lands just past the tail and then moves toward the head past every
   // entry of strictly lower priority, so entries of equal priority stay in arrival
   // order. Every index step wraps around the ring.
   function automatic queue_result_type apply_to_shadow(queue_op_type item);
      queue_result_type res;
      int unsigned      pos;
      int unsigned      prev;
      int unsigned      ahead;
      entry_type        swap;
      res.status = STATUS_OK;
      res.data = '0;
      res.prio = '0;
      if (item.op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = (shadow_head + shadow_count) % DEPTH;
            ahead = shadow_count;
            shadow_slots[pos].data = item.data;
            shadow_slots[pos].prio = item.prio;
            shadow_count++;
            prev = (pos + DEPTH - 1) % DEPTH;
            while (ahead > 0 &&
                   $signed(shadow_slots[pos].prio) > $signed(shadow_slots[prev].prio)) begin
               swap = shadow_slots[prev];
               shadow_slots[prev] = shadow_slots[pos];
               shadow_slots[pos] = swap;
               pos = prev;
               prev = (pos + DEPTH - 1) % DEPTH;
               ahead--;
            end
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.data = shadow_slots[shadow_head].data;
            res.prio = shadow_slots[shadow_head].prio;
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_count--;
         end
      end
      res.occupancy = shadow_count[OCC_W-1:0];
      return res;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $realtime, what, got, exp_val);
      mismatch_count++;
   endtask

   task automatic queue_op(logic op, logic [DATA_W-1:0] data, logic [DATA_W-1:0] prio,
                           int gap, bit drain_first);
      queue_op_type item;
      item.op = op;
      item.data = data;
      item.prio = prio;
      item.gap = gap;
      item.drain_first = drain_first;
      op_backlog.push_back(item);
   endtask

   // Driver. All request signals change on the falling edge. A presented transaction
   // is held until the rising edge that accepts it; after that the next operation is
   // presented at once, so start stays high through back-to-back transactions and is
   // only written once per falling edge.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         // Still waiting for the block to take the current transaction.
      end else if (op_backlog.size() == 0) begin
         start <= 1'b0;
      end else if (op_backlog[0].drain_first && awaited_results.size() != 0) begin
         start <= 1'b0;
      end else if (gap_count < op_backlog[0].gap) begin
         gap_count++;
         start <= 1'b0;
      end else begin
         next_op = op_backlog.pop_front();
         gap_count = 0;
         req_operation <= next_op.op;
         req_item_data <= next_op.data;
         req_item_priority <= next_op.prio;
         start <= 1'b1;
      end
   end

   // Monitor. On each rising edge it first checks a strobed result against the oldest
   // outstanding prediction and then, if a transaction is accepted on this edge, feeds
   // it to the shadow queue. The result of an operation never comes on the edge that
   // accepts it, so this order is safe.
   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with no operation outstanding", 64'(rsp_status), 64'd0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_removed_data !== want.data)
                  report_mismatch("removed data", 64'(rsp_removed_data), 64'(want.data));
               if (rsp_removed_priority !== want.prio)
                  report_mismatch("removed priority", 64'(rsp_removed_priority),
                                  64'(want.prio));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch("occupancy", 64'(rsp_occupancy), 64'(want.occupancy));
            end
         end
         if (start && !busy) begin
            taken_op.op = req_operation;
            taken_op.data = req_item_data;
            taken_op.prio = req_item_priority;
            taken_op.gap = 0;
            taken_op.drain_first = 1'b0;
            awaited_results.push_back(apply_to_shadow(taken_op));
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [DATA_W-1:0] fill_prio[16];
      logic [DATA_W-1:0] fill_data[16];
      int                total;
      int                phase_len;
      int                insert_weight;
      bit                no_gaps;
      bit                tie_heavy;
      logic [DATA_W-1:0] prio;
      int                gap;

      // Directed part. A delete on the empty queue comes first. Then sixteen inserts
      // fill the queue with the priority and data extremes and several ties (four
      // entries at five, two at the largest and two at the smallest priority), so that
      // arrival order among equals is visible when they come out. One more insert must
      // report full, and four deletes then take entries from the head.
      fill_prio = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                    32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0001,
                    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0003, 32'hffff_fffe,
                    32'h0000_0002, 32'h7fff_fffe, 32'h8000_0001, 32'h0000_0005};
      fill_data = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000,
                    32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h5555_5555,
                    32'haaaa_aaaa, 32'h0000_0004, 32'h1234_5678, 32'hfedc_ba98,
                    32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0005, 32'h0000_0006};
      queue_op(OP_DELETE, 32'hdead_beef, 32'h1234_5678, 0, 1'b0);
      for (int i = 0; i < 16; i++)
         queue_op(OP_INSERT, fill_data[i], fill_prio[i], 0, 1'b0);
      queue_op(OP_INSERT, 32'h0bad_0bad, 32'h7fff_ffff, 0, 1'b0);
      for (int i = 0; i < 4; i++)
         queue_op(OP_DELETE, $urandom, $urandom, 0, 1'b0);

      // Random part, in phases. Each phase leans toward inserts or toward deletes, so
      // the queue swings between full and empty and its head walks around the ring.
      // Some phases draw priorities from a narrow band to make ties common, and some
      // run without idle cycles. A phase may open by waiting for the queue's results
      // to drain, and the first one always does.
      total = 0;
      while (total < RANDOM_OPS) begin
         phase_len = $urandom_range(20, 80);
         insert_weight = $urandom_range(1, 9);
         no_gaps = ($urandom_range(0, 3) == 0);
         tie_heavy = $urandom_range(0, 1);
         for (int i = 0; i < phase_len; i++) begin
            if (tie_heavy)
               prio = 32'($signed($urandom_range(0, 4)) - 2);
            else
               prio = $urandom;
            case ($urandom_range(0, 19))
               0: prio = 32'h7fff_ffff;
               1: prio = 32'h8000_0000;
               default: begin
               end
            endcase
            gap = no_gaps ? 0 : $urandom_range(0, 3);
            queue_op(($urandom_range(1, 10) <= insert_weight) ? OP_INSERT : OP_DELETE,
                     $urandom, prio, gap,
                     (i == 0) && (total == 0 || $urandom_range(0, 2) == 0));
         end
         total += phase_len;
      end

      // Reset is held and then released on a falling edge.
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Wait for the last transaction to be accepted and for its result, then keep clocking
      // so that any stray result would still be caught.
      while (op_backlog.size() != 0 || start)
         @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog. A correct run needs well under a tenth of this time even with every
   // insert walking the whole queue and every operation preceded by the longest gap.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sorted_ring_priority_queue.f @@
rtl/core/srpq_pkg.sv
rtl/core/srpq_ram.sv
rtl/core/sorted_ring_priority_queue.sv
rtl/core/srpq_checker.sv
bench/tb.sv
